// File: design/itbe_pkg.sv
// ----------------------------------------------------------------------------
// itbe_pkg
// Shared types and constants for the I2C target bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package itbe_pkg;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ADDR = 2'd1;
    localparam logic [1:0] PH_RX   = 2'd2;
    localparam logic [1:0] PH_TX   = 2'd3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_PUSH   = 1'b1;

    localparam logic REG_OWN_ADDRESS = 1'b0;
    localparam logic REG_ACK_ENABLE  = 1'b1;

    localparam logic [3:0] BIT_ACK   = 4'd8;
    localparam logic [3:0] BIT_AFTER = 4'd9;
    localparam logic [3:0] BIT_MAX   = 4'd15;

    typedef struct packed {
        logic       op;
        logic       sda_level;
        logic       scl_level;
        logic [7:0] tx_byte;
    } t_item;

    typedef struct packed {
        logic       sda_pull_low;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       write_done;
        logic       read_request;
        logic       push_dropped;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic       index;
        logic [7:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [7:0] wdata;
    } t_fifo_ctl;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] head_data;
    } t_fifo_sts;

endpackage

`default_nettype wire

// File: design/i2c_target_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_target_bit_engine
// I2C target engine fed with sampled SDA/SCL levels and transmit bytes.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-----------------------------------
//   in      | in  | i_in_valid/o_in_stall  | op, sda_level, scl_level, tx_byte
//   out     | out | o_out_valid/i_out_stall| sda_pull_low, rx_valid, rx_data,
//           |     |                        | write_done, read_request,
//           |     |                        | push_dropped
//   cfg     | in  | i_cfg_valid/o_cfg_ready| cfg_index, cfg_data
//
// One item per cycle while the output is not stalled. Each item passes the input
// register, then one pass of the bus logic into the result register. The transmit
// queue keeps its head prefetched so a pop completes in the same pass. Reset is
// immediate, with no clearing pass. A stalled output holds its result while the
// input register still takes one more transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_target_bit_engine #(
    parameter int TX_FIFO_DEPTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire        i_op,
    input  wire        i_sda_level,
    input  wire        i_scl_level,
    input  wire  [7:0] i_tx_byte,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic       o_sda_pull_low,
    output logic       o_rx_valid,
    output logic [7:0] o_rx_data,
    output logic       o_write_done,
    output logic       o_read_request,
    output logic       o_push_dropped,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_index,
    input  wire  [7:0] i_cfg_data
);
    import itbe_pkg::*;

    logic      r_in_valid;
    t_item     r_in;
    logic      r_out_valid;
    t_result   r_out;
    logic      go;
    t_cfg_wr   cfg;
    t_fifo_ctl fctl;
    t_fifo_sts fsts;
    t_result   res;

    assign go         = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !go;
    assign o_cfg_ready = 1'b1;

    assign cfg.valid = i_cfg_valid;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in.op        <= i_op;
            r_in.sda_level <= i_sda_level;
            r_in.scl_level <= i_scl_level;
            r_in.tx_byte   <= i_tx_byte;
        end
    end

    itbe_fifo #(
        .DEPTH (TX_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fctl),
        .o_sts   (fsts)
    );

    itbe_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .i_fifo  (fsts),
        .o_fifo  (fctl),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sda_pull_low = r_out.sda_pull_low;
    assign o_rx_valid     = r_out.rx_valid;
    assign o_rx_data      = r_out.rx_data;
    assign o_write_done   = r_out.write_done;
    assign o_read_request = r_out.read_request;
    assign o_push_dropped = r_out.push_dropped;

    a_go_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> r_out_valid)
        else $error("processed transaction did not reach result register");

    a_rx_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_rx_valid) |-> (o_rx_data == 8'd0))
        else $error("rx_data nonzero without rx_valid");

    a_drop_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_push_dropped) |->
            (!o_rx_valid && !o_write_done && !o_read_request))
        else $error("dropped push flagged together with bus events");

    a_rx_not_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_rx_valid && o_read_request))
        else $error("rx byte and read request in one result");

endmodule

`default_nettype wire

// File: design/itbe_fifo.sv
// ----------------------------------------------------------------------------
// itbe_fifo
// Transmit byte queue; the head entry is kept prefetched in a register.
// ----------------------------------------------------------------------------
`default_nettype none

module itbe_fifo #(
    parameter int DEPTH = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  itbe_pkg::t_fifo_ctl  i_ctl,
    output itbe_pkg::t_fifo_sts  o_sts
);
    import itbe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_rd;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.clear) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end else if (i_ctl.pop) begin
            n_head  = wrap_inc(r_head);
            n_count = r_count - CW'(1);
        end else if (i_ctl.push) begin
            n_tail  = wrap_inc(r_tail);
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[r_tail] <= i_ctl.wdata;
        end
        if (i_ctl.push && (r_tail == n_head)) begin
            r_rd <= i_ctl.wdata;
        end else begin
            r_rd <= mem[n_head];
        end
    end

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count == CW'(DEPTH));
    assign o_sts.head_data = r_rd;

endmodule

`default_nettype wire

// File: design/itbe_core.sv
// ----------------------------------------------------------------------------
// itbe_core
// Bus state: start/stop detection, bit shifting, address match, acknowledge.
// ----------------------------------------------------------------------------
`default_nettype none

module itbe_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_go,
    input  itbe_pkg::t_item      i_item,
    input  itbe_pkg::t_cfg_wr    i_cfg,
    input  itbe_pkg::t_fifo_sts  i_fifo,
    output itbe_pkg::t_fifo_ctl  o_fifo,
    output itbe_pkg::t_result    o_res
);
    import itbe_pkg::*;

    logic [6:0] r_own_address;
    logic       r_ack_enable;
    logic [1:0] r_phase,   n_phase;
    logic [3:0] r_bit_idx, n_bit_idx;
    logic [7:0] r_shift_in, n_shift_in;
    logic [7:0] r_shift_out, n_shift_out;
    logic [7:0] r_addr_seen, n_addr_seen;
    logic       r_receiving, n_receiving;
    logic       r_last_sda, n_last_sda;
    logic       r_last_scl, n_last_scl;
    logic       r_drive_low, n_drive_low;

    logic [7:0] own_byte;
    logic [7:0] diff;
    t_result    res;
    t_fifo_ctl  fctl;

    assign own_byte = {r_own_address, 1'b0};

    always_comb begin
        n_phase     = r_phase;
        n_bit_idx   = r_bit_idx;
        n_shift_in  = r_shift_in;
        n_shift_out = r_shift_out;
        n_addr_seen = r_addr_seen;
        n_receiving = r_receiving;
        n_last_sda  = r_last_sda;
        n_last_scl  = r_last_scl;
        n_drive_low = r_drive_low;
        diff        = '0;
        res         = '0;
        fctl        = '0;
        fctl.wdata  = i_item.tx_byte;

        if (i_item.op == OP_PUSH) begin
            if (i_fifo.full) begin
                res.push_dropped = 1'b1;
            end else begin
                fctl.push = 1'b1;
            end
        end else begin
            n_last_sda = i_item.sda_level;
            n_last_scl = i_item.scl_level;

            if ((i_item.sda_level != r_last_sda) && i_item.scl_level) begin
                n_shift_in = '0;
                n_bit_idx  = '0;
                if (!i_item.sda_level) begin
                    n_phase     = PH_ADDR;
                    n_receiving = 1'b1;
                end else begin
                    n_phase = PH_IDLE;
                    if (r_receiving && (r_addr_seen[7:1] == r_own_address)) begin
                        res.write_done = 1'b1;
                    end
                    n_addr_seen = ~own_byte;
                    n_receiving = 1'b1;
                    fctl.clear  = 1'b1;
                end
            end

            if (i_item.scl_level != r_last_scl) begin
                if (i_item.scl_level) begin
                    // rising SCL: sample
                    if (n_phase == PH_ADDR || n_phase == PH_RX) begin
                        if (i_item.sda_level && !n_bit_idx[3]) begin
                            n_shift_in[~n_bit_idx[2:0]] = 1'b1;
                        end
                        if (n_bit_idx != BIT_MAX) begin
                            n_bit_idx = n_bit_idx + 4'd1;
                        end
                    end else if (n_phase == PH_TX) begin
                        if (n_bit_idx == BIT_AFTER) begin
                            if (i_fifo.empty) begin
                                n_phase     = PH_IDLE;
                                n_drive_low = 1'b0;
                            end else begin
                                n_bit_idx   = '0;
                                n_shift_out = i_fifo.head_data;
                                fctl.pop    = 1'b1;
                            end
                        end
                    end
                end else begin
                    // falling SCL: act
                    case (n_phase)
                        PH_ADDR: begin
                            if (n_bit_idx == BIT_ACK) begin
                                n_addr_seen = n_shift_in;
                                diff = n_shift_in ^ own_byte;
                                if (diff[7:1] == 7'd0 && r_ack_enable) begin
                                    n_drive_low = 1'b1;
                                end
                            end else if (n_bit_idx == BIT_AFTER) begin
                                if (r_ack_enable) begin
                                    n_drive_low = 1'b0;
                                end
                                n_shift_in = '0;
                                n_bit_idx  = '0;
                                diff = own_byte ^ n_addr_seen;
                                if (diff == 8'd0) begin
                                    n_phase = PH_RX;
                                end else if (diff == 8'd1) begin
                                    n_phase          = PH_TX;
                                    n_receiving      = 1'b0;
                                    res.read_request = 1'b1;
                                    if (!i_fifo.empty) begin
                                        n_shift_out = i_fifo.head_data;
                                        fctl.pop    = 1'b1;
                                    end
                                    n_drive_low = !n_shift_out[7];
                                    n_bit_idx   = 4'd1;
                                end else begin
                                    n_phase = PH_IDLE;
                                end
                            end
                        end
                        PH_RX: begin
                            if (n_bit_idx == BIT_ACK) begin
                                res.rx_valid = 1'b1;
                                res.rx_data  = n_shift_in;
                                if (r_ack_enable) begin
                                    n_drive_low = 1'b1;
                                end
                            end else if (n_bit_idx == BIT_AFTER) begin
                                if (r_ack_enable) begin
                                    n_drive_low = 1'b0;
                                end
                                n_shift_in = '0;
                                n_bit_idx  = '0;
                            end
                        end
                        PH_TX: begin
                            if (!n_bit_idx[3]) begin
                                n_drive_low = !n_shift_out[~n_bit_idx[2:0]];
                            end else begin
                                n_drive_low = 1'b0;
                            end
                            if (n_bit_idx != BIT_MAX) begin
                                n_bit_idx = n_bit_idx + 4'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
        res.sda_pull_low = n_drive_low;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= '0;
            r_ack_enable  <= 1'b0;
            r_phase       <= PH_IDLE;
            r_bit_idx     <= '0;
            r_shift_in    <= '0;
            r_shift_out   <= '0;
            r_addr_seen   <= 8'hFF;
            r_receiving   <= 1'b1;
            r_last_sda    <= 1'b1;
            r_last_scl    <= 1'b1;
            r_drive_low   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_OWN_ADDRESS: begin
                    r_own_address <= i_cfg.data[6:0];
                    r_addr_seen   <= ~{i_cfg.data[6:0], 1'b0};
                end
                REG_ACK_ENABLE: begin
                    r_ack_enable <= i_cfg.data[0];
                end
                default: begin
                end
            endcase
        end else if (i_go) begin
            r_phase     <= n_phase;
            r_bit_idx   <= n_bit_idx;
            r_shift_in  <= n_shift_in;
            r_shift_out <= n_shift_out;
            r_addr_seen <= n_addr_seen;
            r_receiving <= n_receiving;
            r_last_sda  <= n_last_sda;
            r_last_scl  <= n_last_scl;
            r_drive_low <= n_drive_low;
        end
    end

    always_comb begin
        o_fifo       = fctl;
        o_fifo.push  = fctl.push & i_go;
        o_fifo.pop   = fctl.pop & i_go;
        o_fifo.clear = fctl.clear & i_go;
    end

    assign o_res = res;

endmodule

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for i2c_target_bit_engine. A short table of bus samples
// and pushes comes first, then generated I2C transactions (reads, writes,
// repeated starts, truncated bytes, pin noise, queue overflow) under several
// address and acknowledge settings. Every result is compared with an
// in-bench model of the engine, or with the table's value for fixed rows.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import itbe_pkg::*;

    localparam int FIFO_DEPTH  = 16;
    localparam int PHASE_ITEMS = 145;

    typedef struct packed {
        t_item   item;
        logic    fixed;
        t_result want;
    } t_dir_row;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    wire        in_stall;
    logic       op;
    logic       sda;
    logic       scl;
    logic [7:0] tx_byte;
    wire        out_valid;
    logic       out_stall;
    wire        res_pull;
    wire        res_rx_valid;
    wire  [7:0] res_rx_data;
    wire        res_wdone;
    wire        res_rreq;
    wire        res_drop;
    logic       cfg_valid;
    wire        cfg_ready;
    logic       cfg_index;
    logic [7:0] cfg_data;

    // engine model state
    logic [1:0] eng_phase  = PH_IDLE;
    logic [3:0] bit_cnt    = '0;
    logic [7:0] rx_shift   = '0;
    logic [7:0] tx_shift   = '0;
    logic [7:0] addr_byte  = 8'hFF;
    logic       is_write   = 1'b1;
    logic       bus_sda    = 1'b1;
    logic       bus_scl    = 1'b1;
    logic       pull_low   = 1'b0;
    logic [7:0] fifo_mem [FIFO_DEPTH];
    logic [4:0] fifo_level = '0;
    logic [3:0] fifo_rd    = '0;
    logic [6:0] own_addr   = '0;
    logic       ack_on     = 1'b0;

    t_result  expected_q [$];
    t_dir_row dir_rows [$];

    bit calm      = 1'b0;
    bit hold_long = 1'b0;
    int fail_count;
    int items_sent;
    int n_pushes, n_dropped, n_rx, n_reads, n_wdone;

    i2c_target_bit_engine DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_op           (op),
        .i_sda_level    (sda),
        .i_scl_level    (scl),
        .i_tx_byte      (tx_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_sda_pull_low (res_pull),
        .o_rx_valid     (res_rx_valid),
        .o_rx_data      (res_rx_data),
        .o_write_done   (res_wdone),
        .o_read_request (res_rreq),
        .o_push_dropped (res_drop),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    function automatic void count_up();
        if (bit_cnt != BIT_MAX) bit_cnt++;
    endfunction

    function automatic void tx_load();
        if (fifo_level != 0) begin
            tx_shift = fifo_mem[fifo_rd];
            fifo_rd++;
            fifo_level--;
        end
    endfunction

    function automatic void tx_next_bit();
        pull_low = (bit_cnt < BIT_ACK) ? ~tx_shift[7 - bit_cnt] : 1'b0;
        count_up();
    endfunction

    function automatic t_result engine_step(input t_item it);
        t_result    r;
        logic       prev_sda;
        logic       prev_scl;
        logic [3:0] slot;
        logic [7:0] own;
        logic [7:0] diff;
        r   = '0;
        own = {own_addr, 1'b0};
        if (it.op == OP_PUSH) begin
            if (fifo_level == 5'(FIFO_DEPTH)) begin
                r.push_dropped = 1'b1;
            end else begin
                slot = fifo_rd + fifo_level[3:0];
                fifo_mem[slot] = it.tx_byte;
                fifo_level++;
            end
        end else begin
            prev_sda = bus_sda;
            prev_scl = bus_scl;
            bus_sda  = it.sda_level;
            bus_scl  = it.scl_level;
            // SDA moving while SCL high: start or stop
            if (it.scl_level && it.sda_level != prev_sda) begin
                rx_shift = '0;
                bit_cnt  = '0;
                if (!it.sda_level) begin
                    eng_phase = PH_ADDR;
                end else begin
                    eng_phase = PH_IDLE;
                    if (is_write && addr_byte[7:1] == own_addr) r.write_done = 1'b1;
                    addr_byte  = ~own;
                    fifo_level = '0;
                    fifo_rd    = '0;
                end
                is_write = 1'b1;
            end
            if (it.scl_level && !prev_scl) begin
                if (eng_phase == PH_ADDR || eng_phase == PH_RX) begin
                    if (it.sda_level && bit_cnt < BIT_ACK) rx_shift[7 - bit_cnt] = 1'b1;
                    count_up();
                end else if (eng_phase == PH_TX && bit_cnt == BIT_AFTER) begin
                    if (fifo_level == 0) begin
                        eng_phase = PH_IDLE;
                        pull_low  = 1'b0;
                    end else begin
                        bit_cnt = '0;
                        tx_load();
                    end
                end
            end else if (!it.scl_level && prev_scl) begin
                case (eng_phase)
                    PH_ADDR: begin
                        if (bit_cnt == BIT_ACK) begin
                            addr_byte = rx_shift;
                            if ((addr_byte ^ own) <= 8'd1 && ack_on) pull_low = 1'b1;
                        end else if (bit_cnt == BIT_AFTER) begin
                            if (ack_on) pull_low = 1'b0;
                            rx_shift = '0;
                            bit_cnt  = '0;
                            diff     = own ^ addr_byte;
                            if (diff == 8'd0) begin
                                eng_phase = PH_RX;
                            end else if (diff == 8'd1) begin
                                eng_phase      = PH_TX;
                                is_write       = 1'b0;
                                r.read_request = 1'b1;
                                tx_load();
                                tx_next_bit();
                            end else begin
                                eng_phase = PH_IDLE;
                            end
                        end
                    end
                    PH_RX: begin
                        if (bit_cnt == BIT_ACK) begin
                            r.rx_valid = 1'b1;
                            r.rx_data  = rx_shift;
                            if (ack_on) pull_low = 1'b1;
                        end else if (bit_cnt == BIT_AFTER) begin
                            if (ack_on) pull_low = 1'b0;
                            rx_shift = '0;
                            bit_cnt  = '0;
                        end
                    end
                    PH_TX: tx_next_bit();
                    default: ;
                endcase
            end
        end
        r.sda_pull_low = pull_low;
        return r;
    endfunction

    function automatic t_item sample(input logic s, input logic c);
        return {OP_SAMPLE, s, c, 8'($urandom)};
    endfunction

    function automatic void add_row(input t_item it, input logic fixed, input t_result want);
        dir_rows.push_back({it, fixed, want});
    endfunction

    task automatic send_item(input t_item it, input logic fixed, input t_result want);
        t_result r;
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= it.op;
        sda      <= it.sda_level;
        scl      <= it.scl_level;
        tx_byte  <= it.tx_byte;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = engine_step(it);
        if (fixed) r = want;
        expected_q.push_back(r);
        items_sent++;
        n_pushes  += (it.op == OP_PUSH);
        n_dropped += r.push_dropped;
        n_rx      += r.rx_valid;
        n_reads   += r.read_request;
        n_wdone   += r.write_done;
    endtask

    task automatic pin(input logic s, input logic c);
        send_item(sample(s, c), 1'b0, '0);
    endtask

    task automatic push_byte(input logic [7:0] b);
        send_item({OP_PUSH, 1'($urandom), 1'($urandom), b}, 1'b0, '0);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [6:0] addr, input logic ack);
        cfg_valid <= 1'b1;
        cfg_index <= REG_OWN_ADDRESS;
        cfg_data  <= {1'($urandom), addr};
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        own_addr  = addr;
        addr_byte = ~{addr, 1'b0};
        cfg_index <= REG_ACK_ENABLE;
        cfg_data  <= {7'($urandom), ack};
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        ack_on = ack;
        cfg_valid <= 1'b0;
    endtask

    // master level, or wired-AND with the target when it may drive the slot
    task automatic bus_bit(input logic mbit, input logic shared);
        logic lvl;
        lvl = (shared && $urandom_range(0, 7) != 0) ? (mbit & ~pull_low) : mbit;
        if ($urandom_range(0, 15) == 0) push_byte(8'($urandom));
        if (lvl != bus_sda) pin(lvl, 1'b0);
        pin(lvl, 1'b1);
        if ($urandom_range(0, 9) == 0) pin(lvl, 1'b1);
        pin(lvl, 1'b0);
    endtask

    task automatic bus_byte(input logic [7:0] b, input logic shared);
        int i;
        for (i = 7; i >= 0; i--) bus_bit(b[i], shared);
    endtask

    task automatic bus_start();
        if (!(bus_sda && bus_scl)) begin
            if (bus_scl) pin(bus_sda, 1'b0);
            pin(1'b1, 1'b0);
            pin(1'b1, 1'b1);
        end
        pin(1'b0, 1'b1);
        pin(1'b0, 1'b0);
    endtask

    task automatic bus_stop();
        if (bus_scl) pin(bus_sda, 1'b0);
        pin(1'b0, 1'b0);
        pin(1'b0, 1'b1);
        pin(1'b1, 1'b1);
    endtask

    task automatic bus_transaction();
        logic [6:0]  target;
        logic        rw;
        int unsigned n;
        int unsigned pick;
        int unsigned k;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 3);
        repeat (n) push_byte(8'($urandom));
        bus_start();
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            // truncated frame
            repeat ($urandom_range(1, 12)) bus_bit(1'($urandom), 1'b0);
        end else begin
            if (pick < 15)      target = own_addr;
            else if (pick < 18) target = own_addr ^ (7'd1 << $urandom_range(0, 6));
            else                target = 7'($urandom);
            rw = 1'($urandom);
            bus_byte({target, rw}, 1'b0);
            bus_bit(1'b1, 1'b1);
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++) begin
                if (!rw) begin
                    bus_byte(8'($urandom), 1'b0);
                    bus_bit(1'b1, 1'b1);
                end else begin
                    bus_byte(8'hFF, 1'b1);
                    bus_bit((k == n - 1) || ($urandom_range(0, 7) == 0), 1'b0);
                end
            end
        end
        if ($urandom_range(0, 5) != 0) bus_stop();
    endtask

    task automatic flag(input string what, input int unsigned want, input int unsigned got);
        $display("%0t mismatch %s: expected %0h, actual %0h", $time, what, want, got);
        fail_count++;
    endtask

    always @(posedge clk) begin : result_check
        t_result got;
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            got = {res_pull, res_rx_valid, res_rx_data, res_wdone, res_rreq, res_drop};
            if (expected_q.size() == 0) begin
                $display("%0t unexpected transaction: actual %h", $time, got);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (got.sda_pull_low !== want.sda_pull_low)
                    flag("sda_pull_low", want.sda_pull_low, got.sda_pull_low);
                if (got.rx_valid !== want.rx_valid)
                    flag("rx_valid", want.rx_valid, got.rx_valid);
                if (got.rx_data !== want.rx_data)
                    flag("rx_data", want.rx_data, got.rx_data);
                if (got.write_done !== want.write_done)
                    flag("write_done", want.write_done, got.write_done);
                if (got.read_request !== want.read_request)
                    flag("read_request", want.read_request, got.read_request);
                if (got.push_dropped !== want.push_dropped)
                    flag("push_dropped", want.push_dropped, got.push_dropped);
            end
        end
    end

    // output backpressure: random bursts, plus one long hold-off on request
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_long) begin
                hold_long = 1'b0;
                out_stall <= 1'b1;
                repeat (64) @(posedge clk);
                out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int       i;
        int       ph;
        int       goal;
        t_dir_row row;
        logic [6:0] addr;
        logic       ack;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        op        <= OP_SAMPLE;
        sda       <= 1'b1;
        scl       <= 1'b1;
        tx_byte   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_OWN_ADDRESS;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        configure(7'h7F, 1'b1);

        // read from address 7F with ack on, two bytes queued
        add_row(sample(1'b1, 1'b1), 1'b1, '0);
        add_row({OP_PUSH, 1'b0, 1'b0, 8'h00}, 1'b1, '0);
        add_row({OP_PUSH, 1'b1, 1'b1, 8'hFF}, 1'b1, '0);
        add_row(sample(1'b0, 1'b1), 1'b1, '0);
        for (i = 0; i < 8; i++) begin
            add_row(sample(1'b1, 1'b0), 1'b0, '0);
            add_row(sample(1'b1, 1'b1), 1'b0, '0);
        end
        add_row(sample(1'b0, 1'b0), 1'b1, {1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0});
        add_row(sample(1'b0, 1'b1), 1'b0, '0);
        add_row(sample(1'b0, 1'b0), 1'b1, {1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0});
        add_row(sample(1'b0, 1'b1), 1'b0, '0);
        // stop leaves the pull-down as it was
        add_row(sample(1'b1, 1'b1), 1'b1, {1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0});
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_item(row.item, row.fixed, row.want);
        end

        for (ph = 0; ph < 6; ph++) begin
            drain_results();
            case (ph)
                0: begin addr = 7'h00; ack = 1'b1; end
                1: begin addr = 7'h7F; ack = 1'b0; end
                2: begin addr = 7'($urandom); ack = 1'b1; end
                3: begin addr = 7'($urandom); ack = 1'b0; end
                4: begin addr = 7'h7F; ack = 1'b1; end
                default: begin addr = 7'($urandom); ack = 1'($urandom); end
            endcase
            configure(addr, ack);
            calm = (ph == 5);
            if (ph == 2) hold_long = 1'b1;
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                if ($urandom_range(0, 9) < 8) begin
                    bus_transaction();
                end else begin
                    repeat ($urandom_range(1, 6)) pin(1'($urandom), 1'($urandom));
                end
            end
        end
        drain_results();

        $display("run: %0d transactions in, %0d byte pushes (%0d refused), %0d bytes received",
                 items_sent, n_pushes, n_dropped, n_rx);
        $display("run: %0d read requests, %0d completed writes, six address/ack settings",
                 n_reads, n_wdone);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: i2c_target_bit_engine.f
design/itbe_pkg.sv
design/itbe_fifo.sv
design/itbe_core.sv
design/i2c_target_bit_engine.sv
dv/tb.sv
